// ===== src/mldc_pkg.sv =====
// Shared types, codes, constants and gamma table of the motion light dimmer.
`default_nettype none
package mldc_pkg;

	// Event codes on the input channel
	typedef enum logic [1:0] {
		CMD_MOTION = 2'd0,
		CMD_TICK   = 2'd1,
		CMD_LOOP   = 2'd2
	} cmd_t;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DARK_THR     = 3'd0,
		REG_AUTO_ON      = 3'd1,
		REG_MAN_HOLD     = 3'd2,
		REG_CRIT_MV      = 3'd3,
		REG_RESTORE_MV   = 3'd4,
		REG_CRIT_TEMP    = 3'd5,
		REG_RESTORE_TEMP = 3'd6
	} reg_idx_t;

	// Reset values of the configuration registers
	localparam logic [9:0]        RST_DARK_THR     = 10'd512;
	localparam logic [15:0]       RST_AUTO_ON      = 16'd600;
	localparam logic [15:0]       RST_MAN_HOLD     = 16'd60;
	localparam logic [15:0]       RST_CRIT_MV      = 16'd10000;
	localparam logic [15:0]       RST_RESTORE_MV   = 16'd11000;
	localparam logic signed [9:0] RST_CRIT_TEMP    = 10'sd85;
	localparam logic signed [9:0] RST_RESTORE_TEMP = 10'sd70;

	localparam logic [31:0] MANUAL_PERIOD_TICKS = 32'd100;
	localparam logic [7:0]  SLOW_FADE_LIMIT     = 8'd20;
	localparam logic [7:0]  LEVEL_MAX           = 8'd255;

	typedef struct packed {
		logic [9:0]        dark_thr;
		logic [15:0]       auto_on_ticks;
		logic [15:0]       man_hold;
		logic [15:0]       crit_mv;
		logic [15:0]       restore_mv;
		logic signed [9:0] crit_temp;
		logic signed [9:0] restore_temp;
	} cfg_t;

	typedef struct packed {
		logic [1:0]        command;
		logic [15:0]       supply_mv;
		logic signed [9:0] board_temp_c;
		logic [9:0]        ambient_light;
		logic              plus_pressed;
		logic              minus_pressed;
	} item_t;

	typedef struct packed {
		logic [7:0] pwm_duty;
		logic       driver_disable;
		logic       run_led;
		logic       fail_led;
		logic       protection_active;
	} result_t;

	localparam logic [7:0] GAMMA_ROM [256] = '{
		8'd0, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
		8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
		8'd1, 8'd2, 8'd2, 8'd2, 8'd2, 8'd3, 8'd3, 8'd3,
		8'd3, 8'd4, 8'd4, 8'd4, 8'd5, 8'd5, 8'd5, 8'd6,
		8'd6, 8'd6, 8'd7, 8'd7, 8'd7, 8'd8, 8'd8, 8'd9,
		8'd9, 8'd9, 8'd10, 8'd10, 8'd11, 8'd11, 8'd12, 8'd12,
		8'd13, 8'd13, 8'd13, 8'd14, 8'd14, 8'd15, 8'd16, 8'd16,
		8'd17, 8'd17, 8'd18, 8'd18, 8'd19, 8'd19, 8'd20, 8'd21,
		8'd21, 8'd22, 8'd22, 8'd23, 8'd24, 8'd24, 8'd25, 8'd25,
		8'd26, 8'd27, 8'd27, 8'd28, 8'd29, 8'd30, 8'd30, 8'd31,
		8'd32, 8'd32, 8'd33, 8'd34, 8'd35, 8'd35, 8'd36, 8'd37,
		8'd38, 8'd38, 8'd39, 8'd40, 8'd41, 8'd42, 8'd42, 8'd43,
		8'd44, 8'd45, 8'd46, 8'd46, 8'd47, 8'd48, 8'd49, 8'd50,
		8'd51, 8'd52, 8'd53, 8'd53, 8'd54, 8'd55, 8'd56, 8'd57,
		8'd58, 8'd59, 8'd60, 8'd61, 8'd62, 8'd63, 8'd64, 8'd65,
		8'd66, 8'd67, 8'd68, 8'd69, 8'd70, 8'd71, 8'd72, 8'd73,
		8'd74, 8'd75, 8'd76, 8'd77, 8'd78, 8'd79, 8'd80, 8'd81,
		8'd82, 8'd83, 8'd84, 8'd86, 8'd87, 8'd88, 8'd89, 8'd90,
		8'd91, 8'd92, 8'd93, 8'd95, 8'd96, 8'd97, 8'd98, 8'd99,
		8'd100, 8'd102, 8'd103, 8'd104, 8'd105, 8'd106, 8'd108, 8'd109,
		8'd110, 8'd111, 8'd113, 8'd114, 8'd115, 8'd116, 8'd118, 8'd119,
		8'd120, 8'd122, 8'd123, 8'd124, 8'd125, 8'd127, 8'd128, 8'd129,
		8'd131, 8'd132, 8'd133, 8'd135, 8'd136, 8'd137, 8'd139, 8'd140,
		8'd142, 8'd143, 8'd144, 8'd146, 8'd147, 8'd149, 8'd150, 8'd151,
		8'd153, 8'd154, 8'd156, 8'd157, 8'd159, 8'd160, 8'd162, 8'd163,
		8'd164, 8'd166, 8'd167, 8'd169, 8'd170, 8'd172, 8'd173, 8'd175,
		8'd176, 8'd178, 8'd180, 8'd181, 8'd183, 8'd184, 8'd186, 8'd187,
		8'd189, 8'd190, 8'd192, 8'd194, 8'd195, 8'd197, 8'd198, 8'd200,
		8'd202, 8'd203, 8'd205, 8'd207, 8'd208, 8'd210, 8'd211, 8'd213,
		8'd215, 8'd216, 8'd218, 8'd220, 8'd221, 8'd223, 8'd225, 8'd227,
		8'd228, 8'd230, 8'd232, 8'd233, 8'd235, 8'd237, 8'd239, 8'd240,
		8'd242, 8'd244, 8'd246, 8'd247, 8'd249, 8'd251, 8'd253, 8'd255
	};

endpackage
`default_nettype wire

// ===== src/mldc_if.sv =====
// Valid/ready channel interfaces for event beats and status beats.
`default_nettype none
interface mldc_event_if;
	logic              valid;
	logic              ready;
	logic [1:0]        command;
	logic [15:0]       supply_mv;
	logic signed [9:0] board_temp_c;
	logic [9:0]        ambient_light;
	logic              plus_pressed;
	logic              minus_pressed;

	modport source (output valid, command, supply_mv, board_temp_c, ambient_light,
		plus_pressed, minus_pressed, input ready);
	modport sink (input valid, command, supply_mv, board_temp_c, ambient_light,
		plus_pressed, minus_pressed, output ready);
endinterface

interface mldc_status_if;
	logic       valid;
	logic       ready;
	logic [7:0] pwm_duty;
	logic       driver_disable;
	logic       run_led;
	logic       fail_led;
	logic       protection_active;

	modport source (output valid, pwm_duty, driver_disable, run_led, fail_led,
		protection_active, input ready);
	modport sink (input valid, pwm_duty, driver_disable, run_led, fail_led,
		protection_active, output ready);
endinterface
`default_nettype wire

// ===== src/mldc_cfg_regs.sv =====
// Configuration register file of the motion light dimmer.
`default_nettype none
module mldc_cfg_regs
	import mldc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_en,
	input  wire logic [CFG_IDX_W-1:0]  addr,
	input  wire logic [CFG_DATA_W-1:0] data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dark_thr      <= RST_DARK_THR;
			cfg_q.auto_on_ticks <= RST_AUTO_ON;
			cfg_q.man_hold      <= RST_MAN_HOLD;
			cfg_q.crit_mv       <= RST_CRIT_MV;
			cfg_q.restore_mv    <= RST_RESTORE_MV;
			cfg_q.crit_temp     <= RST_CRIT_TEMP;
			cfg_q.restore_temp  <= RST_RESTORE_TEMP;
		end else if (wr_en) begin
			unique case (addr)
				REG_DARK_THR:     cfg_q.dark_thr      <= data[9:0];
				REG_AUTO_ON:      cfg_q.auto_on_ticks <= data;
				REG_MAN_HOLD:     cfg_q.man_hold      <= data;
				REG_CRIT_MV:      cfg_q.crit_mv       <= data;
				REG_RESTORE_MV:   cfg_q.restore_mv    <= data;
				REG_CRIT_TEMP:    cfg_q.crit_temp     <= data[9:0];
				REG_RESTORE_TEMP: cfg_q.restore_temp  <= data[9:0];
				default: ;	// unmapped index, write dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ===== src/mldc_core.sv =====
// Controller state and the single-pass next-state logic for one event beat.
`default_nettype none
module mldc_core
	import mldc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	input  wire item_t item,
	input  wire logic  advance,
	output result_t    result
);

	logic [31:0] tick_count_q, tick_count_n;
	logic [31:0] period_mark_q, period_mark_n;
	logic        motion_req_q, motion_req_n;
	logic [15:0] motion_left_q, motion_left_n;
	logic [7:0]  manual_level_q, manual_level_n;
	logic [15:0] manual_left_q, manual_left_n;
	logic [7:0]  auto_level_q, auto_level_n;
	logic        protect_q, protect_n;
	logic        blink_q, blink_n;
	logic [9:0]  last_ambient_q, last_ambient_n;
	logic [7:0]  duty_q, duty_n;
	logic [31:0] since_mark;

	assign since_mark = tick_count_q - period_mark_q;

	always_comb begin
		tick_count_n   = tick_count_q;
		period_mark_n  = period_mark_q;
		motion_req_n   = motion_req_q;
		motion_left_n  = motion_left_q;
		manual_level_n = manual_level_q;
		manual_left_n  = manual_left_q;
		auto_level_n   = auto_level_q;
		protect_n      = protect_q;
		blink_n        = blink_q;
		last_ambient_n = last_ambient_q;
		duty_n         = duty_q;
		case (item.command)
			CMD_MOTION: begin
				if (last_ambient_q < cfg.dark_thr) begin
					motion_req_n  = 1'b1;
					motion_left_n = cfg.auto_on_ticks;
				end
				manual_left_n = cfg.man_hold;
			end
			CMD_TICK: begin
				tick_count_n = tick_count_q + 32'd1;
				if (motion_req_q && motion_left_q != '0)
					motion_left_n = motion_left_q - 16'd1;
				if (motion_left_n == '0)
					motion_req_n = 1'b0;
			end
			CMD_LOOP: begin
				last_ambient_n = item.ambient_light;
				// manual timeout and slow fade, once per period
				if (since_mark > MANUAL_PERIOD_TICKS) begin
					period_mark_n = tick_count_q;
					if (manual_left_n != '0)
						manual_left_n = manual_left_n - 16'd1;
					if (manual_level_n != '0 && manual_level_n < SLOW_FADE_LIMIT)
						manual_level_n = manual_level_n - 8'd1;
				end
				if (item.minus_pressed && manual_level_n != '0) begin
					manual_left_n  = cfg.man_hold;
					manual_level_n = manual_level_n - 8'd1;
				end
				if (item.plus_pressed && manual_level_n != LEVEL_MAX) begin
					manual_left_n  = cfg.man_hold;
					manual_level_n = manual_level_n + 8'd1;
				end
				if (manual_left_n == '0 && manual_level_n != '0)
					manual_level_n = manual_level_n - 8'd1;
				// protection with hysteresis; release wins when both hold
				if (item.supply_mv <= cfg.crit_mv || item.board_temp_c > cfg.crit_temp) begin
					auto_level_n = '0;
					motion_req_n = 1'b0;
					protect_n    = 1'b1;
				end
				if (item.supply_mv >= cfg.restore_mv &&
					item.board_temp_c < cfg.restore_temp)
					protect_n = 1'b0;
				if (protect_n) begin
					blink_n = ~blink_q;
				end else begin
					blink_n = 1'b0;
					if (motion_req_n && auto_level_n != LEVEL_MAX)
						auto_level_n = auto_level_n + 8'd1;
					if (!motion_req_n && auto_level_n != '0)
						auto_level_n = auto_level_n - 8'd1;
					if (manual_level_n != '0) begin
						duty_n       = GAMMA_ROM[manual_level_n];
						auto_level_n = '0;
					end else begin
						duty_n = GAMMA_ROM[auto_level_n];
					end
				end
			end
			default: ;	// unused code: state untouched
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q   <= '0;
			period_mark_q  <= '0;
			motion_req_q   <= 1'b0;
			motion_left_q  <= '0;
			manual_level_q <= '0;
			manual_left_q  <= '0;
			auto_level_q   <= '0;
			protect_q      <= 1'b0;
			blink_q        <= 1'b0;
			last_ambient_q <= '0;
			duty_q         <= '0;
		end else if (advance) begin
			tick_count_q   <= tick_count_n;
			period_mark_q  <= period_mark_n;
			motion_req_q   <= motion_req_n;
			motion_left_q  <= motion_left_n;
			manual_level_q <= manual_level_n;
			manual_left_q  <= manual_left_n;
			auto_level_q   <= auto_level_n;
			protect_q      <= protect_n;
			blink_q        <= blink_n;
			last_ambient_q <= last_ambient_n;
			duty_q         <= duty_n;
		end
	end

	always_comb begin
		result.pwm_duty          = duty_n;
		result.driver_disable    = protect_n;
		result.run_led           = ~protect_n;
		result.fail_led          = blink_n;
		result.protection_active = protect_n;
	end

endmodule
`default_nettype wire

// ===== src/motion_light_dimmer_controller_unit.sv =====
// Top level of the motion light dimmer controller: configuration registers, input stage, core and status register.
`default_nettype none
// Motion-triggered LED dimmer. Every event beat (motion, timer tick or loop
// pass with measurements) yields exactly one status beat carrying the gamma
// corrected duty and the protection flags as they stand after that event.
// Throughput is one beat per clock while the sink keeps up: the whole update
// of the controller state is a single pass of compare/increment logic between
// the input register and the status register. An accepted event beat passes
// through the input register, then the status register, where it becomes the
// valid status beat. The input side keeps taking beats while a finished status
// beat waits for the sink; it stalls only when both the input register and the
// status register are occupied and the sink is not ready.
// Configuration writes take effect on the next clock and are meant to be
// issued while no event beat is in flight. No clearing pass after reset.
module motion_light_dimmer_controller_unit
	import mldc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	mldc_event_if.sink                 events,
	mldc_status_if.source              report,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t result;
	result_t result_s2;
	logic    valid_s2;
	logic    advance;
	logic    take;

	mldc_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.addr   (cfg_addr),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	// Item in stage 1 moves on whenever the status register is free or drained.
	assign advance      = valid_s1 & (~valid_s2 | report.ready);
	assign events.ready = ~valid_s1 | advance;
	assign take         = events.valid & events.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.command       <= events.command;
			item_s1.supply_mv     <= events.supply_mv;
			item_s1.board_temp_c  <= events.board_temp_c;
			item_s1.ambient_light <= events.ambient_light;
			item_s1.plus_pressed  <= events.plus_pressed;
			item_s1.minus_pressed <= events.minus_pressed;
		end
	end

	mldc_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.item    (item_s1),
		.advance (advance),
		.result  (result)
	);

	// Status register: holds the beat until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (report.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign report.valid             = valid_s2;
	assign report.pwm_duty          = result_s2.pwm_duty;
	assign report.driver_disable    = result_s2.driver_disable;
	assign report.run_led           = result_s2.run_led;
	assign report.fail_led          = result_s2.fail_led;
	assign report.protection_active = result_s2.protection_active;

	// An empty input register always takes a beat.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> events.ready)
		else $error("input stage empty but not ready");

	// A stalled item in stage 1 stays there.
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("stalled item dropped from input stage");

	// Run and disable are complementary on every status beat.
	a_led_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (result_s2.run_led != result_s2.driver_disable))
		else $error("run_led and driver_disable disagree");

	// Fail indicator only blinks under protection.
	a_fail_needs_protect: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && result_s2.fail_led) |-> result_s2.protection_active)
		else $error("fail_led set without protection");

endmodule
`default_nettype wire
